// ===== sv/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_cell, skt_enc and sorted_key_table_find_insert; no dependencies.
package skt_pkg;

  localparam int KEY_W  = 32;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 1;

  // Opcodes of a request.
  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT = 1'b1;

  localparam logic [KEY_W-1:0] KEY_LIMIT_RESET = 32'h00FF_FFFF;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             cmp_en;
    logic [KEY_W-1:0] cmp_key;
    logic             ins_en;
    logic [KEY_W-1:0] ins_key;
  } cell_ctrl_t;

endpackage

// ===== sv/sorted_key_table_find_insert.sv =====
// Sorted key table with find and find-or-insert, built as a row of cells.
// A request is compared in the cells at the accept edge, then decided in the
// decide state, which holds busy high, so no new request is taken until it ends.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (rst_n low, synchronous) empties the table, capacity 0, limit 0xFFFFFF.
module sorted_key_table_find_insert #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  output logic                          out_strobe,
  output logic [skt_pkg::STAT_W-1:0]    out_status,
  output logic [skt_pkg::CNT_W-1:0]     out_position,
  output logic [skt_pkg::CNT_W-1:0]     out_entry_count,
  input  logic                          cfg_we,
  input  logic [skt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skt_pkg::KEY_W-1:0]     cfg_wdata
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_DECIDE = 1'b1;

  logic                       state_r, state_nxt;
  logic                       op_r;
  logic [skt_pkg::KEY_W-1:0]  key_r;
  logic [skt_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [skt_pkg::CNT_W-1:0]  cap_r;
  logic [skt_pkg::KEY_W-1:0]  limit_r;
  logic                       out_strobe_r, out_strobe_nxt;
  logic [skt_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [skt_pkg::CNT_W-1:0]  out_position_r, out_position_nxt;

  skt_pkg::cell_ctrl_t        ctrl;
  logic                       accept;
  logic                       ins_en;
  logic [MAX_ENTRIES-1:0]     lt_vec;
  logic [MAX_ENTRIES-1:0]     eq_vec;
  logic [MAX_ENTRIES-1:0]     valid_vec;
  logic [skt_pkg::KEY_W-1:0]  cell_key [MAX_ENTRIES];
  logic [skt_pkg::CNT_W-1:0]  enc_pos;
  logic                       enc_found;
  logic [skt_pkg::CNT_W-1:0]  eff_cap;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_DECIDE);

  // Broadcast to the cells: compare at the accept edge, shift on insert.
  always_comb begin
    ctrl.cmp_en  = accept;
    ctrl.cmp_key = in_key;
    ctrl.ins_en  = ins_en;
    ctrl.ins_key = key_r;
  end

  // The row of cells.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign valid_vec[i] = (32'(count_r) > i);
    if (i == 0) begin : g_first
      skt_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .valid    (valid_vec[i]),
        .prev_key (cell_key[i]),
        .prev_lt  (1'b1),
        .key_r    (cell_key[i]),
        .lt_r     (lt_vec[i]),
        .eq_r     (eq_vec[i])
      );
    end else begin : g_rest
      skt_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .valid    (valid_vec[i]),
        .prev_key (cell_key[i-1]),
        .prev_lt  (lt_vec[i-1]),
        .key_r    (cell_key[i]),
        .lt_r     (lt_vec[i]),
        .eq_r     (eq_vec[i])
      );
    end
  end

  skt_enc #(.N(MAX_ENTRIES)) u_enc (
    .lt       (lt_vec),
    .eq       (eq_vec),
    .position (enc_pos),
    .found    (enc_found)
  );

  // The effective capacity saturates at the number of cells.
  assign eff_cap = (32'(cap_r) > MAX_ENTRIES) ? skt_pkg::CNT_W'(MAX_ENTRIES) : cap_r;

  // Decide the outcome of the request and whether the cells shift.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    ins_en           = 1'b0;
    out_strobe_nxt   = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt        = S_IDLE;
        out_strobe_nxt   = 1'b1;
        out_position_nxt = enc_pos;
        if (op_r == skt_pkg::OP_FIND) begin
          out_status_nxt = enc_found ? skt_pkg::ST_FOUND : skt_pkg::ST_NOT_FOUND;
        end else if (key_r >= limit_r) begin
          out_status_nxt   = skt_pkg::ST_RANGE;
          out_position_nxt = '0;
        end else if (enc_found) begin
          out_status_nxt = skt_pkg::ST_FOUND;
        end else if ({1'b0, count_r} + 10'd1 > {1'b0, eff_cap}) begin
          out_status_nxt = skt_pkg::ST_FULL;
        end else begin
          out_status_nxt = skt_pkg::ST_INSERTED;
          ins_en         = 1'b1;
          count_nxt      = count_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Writing the capacity empties the table.
    if (cfg_we && cfg_index == skt_pkg::REG_CAPACITY) begin
      count_nxt = '0;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cap_r        <= '0;
      limit_r      <= skt_pkg::KEY_LIMIT_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          skt_pkg::REG_CAPACITY:  cap_r   <= cfg_wdata[skt_pkg::CNT_W-1:0];
          skt_pkg::REG_KEY_LIMIT: limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      key_r <= in_key;
    end
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_count = count_r;

  // The decide phase lasts exactly one cycle.
  a_one_decide: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("decide phase longer than one cycle");

  // Every result follows a decide cycle.
  a_strobe_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without a request");

  // An insert places the key inside the occupied part of the table.
  a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == skt_pkg::ST_INSERTED) |->
      (out_position < out_entry_count)) else $error("insert position out of table");

  // The fill count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_ENTRIES) else $error("fill count above table size");

endmodule

// ===== sv/skt_cell.sv =====
// One table cell: holds a key, compares it against the broadcast key and
// shifts up from its lower neighbour on insert. Depends on skt_pkg.
module skt_cell (
  input  logic                     clk,
  input  skt_pkg::cell_ctrl_t      ctrl,
  input  logic                     valid,
  input  logic [skt_pkg::KEY_W-1:0] prev_key,
  input  logic                     prev_lt,
  output logic [skt_pkg::KEY_W-1:0] key_r,
  output logic                     lt_r,
  output logic                     eq_r
);

  logic [skt_pkg::KEY_W-1:0] key_nxt;
  logic                      lt_nxt;
  logic                      eq_nxt;

  // Compare flags: only an occupied cell takes part in the search.
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (ctrl.cmp_en) begin
      lt_nxt = valid && (key_r < ctrl.cmp_key);
      eq_nxt = valid && (key_r == ctrl.cmp_key);
    end
  end

  // On insert, every cell at or above the insertion point moves up by one.
  // The cell at the insertion point is the one whose neighbour below is
  // still smaller than the new key.
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins_en && !lt_r) begin
      key_nxt = prev_lt ? ctrl.ins_key : prev_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

endmodule

// ===== sv/skt_enc.sv =====
// Position encoder: turns the row of compare flags into the insertion
// point and a found flag. Depends on skt_pkg.
module skt_enc #(
  parameter int N = 256
) (
  input  logic [N-1:0]              lt,
  input  logic [N-1:0]              eq,
  output logic [skt_pkg::CNT_W-1:0] position,
  output logic                      found
);

  // The smaller flags form a prefix, so the position is one past the last
  // smaller cell: a one-hot boundary, encoded by OR.
  always_comb begin
    logic nxt_lt;
    position = '0;
    for (int i = 0; i < N; i++) begin
      nxt_lt = (i + 1 < N) ? lt[(i + 1) % N] : 1'b0;
      if (lt[i] && !nxt_lt) begin
        position = position | skt_pkg::CNT_W'(i + 1);
      end
    end
    found = |eq;
  end

endmodule

// ===== verif/sorted_key_table_find_insert_check.sv =====
// Checker for the sorted key table: keeps its own copy of the table, predicts the
// result of every accepted request and compares it with the strobed result.
// Depends on skt_pkg for widths, opcodes, status codes and register indexes.
`timescale 1ns / 100ps

module sorted_key_table_find_insert_check #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_opcode,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  input  logic                          out_strobe,
  input  logic [skt_pkg::STAT_W-1:0]    out_status,
  input  logic [skt_pkg::CNT_W-1:0]     out_position,
  input  logic [skt_pkg::CNT_W-1:0]     out_entry_count,
  input  logic                          cfg_we,
  input  logic [skt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skt_pkg::KEY_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import skt_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
  } lookup_result_t;

  // Shadow copy of the table and of the two registers.
  logic [KEY_W-1:0] stored_keys [0:MAX_ENTRIES-1];
  int               entry_total;
  logic [CNT_W-1:0] capacity_reg;
  logic [KEY_W-1:0] limit_reg;

  lookup_result_t   awaited_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
    entry_total = 0;
    capacity_reg = '0;
    limit_reg = KEY_LIMIT_RESET;
  end

  // Applies one request to the shadow table and returns the result it must give.
  function automatic lookup_result_t apply_request(logic op, logic [KEY_W-1:0] k);
    lookup_result_t res;
    int below;
    int room;
    int j;
    logic hit;
    below = 0;
    while (below < entry_total && stored_keys[below] < k) below++;
    hit = (below < entry_total) && (stored_keys[below] == k);
    room = (int'(capacity_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
    res.position = CNT_W'(below);
    if (op == OP_FIND) begin
      res.status = hit ? ST_FOUND : ST_NOT_FOUND;
    end else if (k >= limit_reg) begin
      // Out of range inserts report position zero and leave the table alone.
      res.status = ST_RANGE;
      res.position = '0;
    end else if (hit) begin
      res.status = ST_FOUND;
    end else if (entry_total + 1 > room) begin
      res.status = ST_FULL;
    end else begin
      // Open a gap at the insertion point by moving larger keys up one place.
      for (j = entry_total; j > below; j--) stored_keys[j] = stored_keys[j-1];
      stored_keys[below] = k;
      entry_total++;
      res.status = ST_INSERTED;
    end
    res.entry_count = CNT_W'(entry_total);
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (!rst_n) begin
      entry_total = 0;
      capacity_reg = '0;
      limit_reg = KEY_LIMIT_RESET;
      awaited_results.delete();
    end else begin
      // Compare a strobed result with the oldest expectation.
      if (out_strobe) begin
        got = '{out_status, out_position, out_entry_count};
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request outstanding: status %0d position %0d count %0d",
                     $realtime, out_status, out_position, out_entry_count);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected status %0d position %0d count %0d, %s %0d %0d %0d",
                       $realtime, want.status, want.position, want.entry_count,
                       "got", got.status, got.position, got.entry_count);
          end
        end
      end
      // Register writes; a capacity write empties the table.
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) begin
          capacity_reg = cfg_wdata[CNT_W-1:0];
          entry_total = 0;
        end else begin
          limit_reg = cfg_wdata;
        end
      end
      // Accepted request.
      if (start && !busy) awaited_results.push_back(apply_request(in_opcode, in_key));
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== verif/sorted_key_table_find_insert_test.sv =====
// Top of the sorted key table testbench: clock, reset, register settings and
// request stimulus, with the checker beside the block giving the failure count.
// Depends on skt_pkg, sorted_key_table_find_insert and its checker module.
`timescale 1ns / 100ps

module sorted_key_table_find_insert_test;
  import skt_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_opcode = OP_FIND;
  logic [KEY_W-1:0]     in_key = '0;
  logic                 out_strobe;
  logic [STAT_W-1:0]    out_status;
  logic [CNT_W-1:0]     out_position;
  logic [CNT_W-1:0]     out_entry_count;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
  logic [KEY_W-1:0]     cfg_wdata = '0;
  int                   fail_count;
  int                   pending;

  // Keys issued in the current phase, reused to provoke hits and neighbours.
  logic [KEY_W-1:0]     issued_keys [$];
  logic [KEY_W-1:0]     phase_limit;
  int                   burst_left = 0;

  always #10 clk = ~clk;

  sorted_key_table_find_insert #(.MAX_ENTRIES(256)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key(in_key),
    .out_strobe(out_strobe), .out_status(out_status), .out_position(out_position),
    .out_entry_count(out_entry_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sorted_key_table_find_insert_check #(.MAX_ENTRIES(256)) u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key(in_key),
    .out_strobe(out_strobe), .out_status(out_status), .out_position(out_position),
    .out_entry_count(out_entry_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] k);
    start <= 1'b1;
    in_opcode <= op;
    in_key <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers; upper capacity bits carry noise the block ignores.
  task automatic set_registers(input logic [CNT_W-1:0] cap, input logic [KEY_W-1:0] lim);
    logic [KEY_W-1:0] noise;
    noise = $urandom;
    cfg_we <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_wdata <= {noise[KEY_W-1:CNT_W], cap};
    @(posedge clk);
    cfg_index <= REG_KEY_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    phase_limit = lim;
    issued_keys.delete();
  endtask

  // Picks a key: a reused one, a neighbour of one, an extreme, or fresh.
  function automatic logic [KEY_W-1:0] pick_key(input int span);
    int r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 35 && issued_keys.size() > 0) begin
      k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    end else if (r < 50 && issued_keys.size() > 0) begin
      k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
      k = $urandom_range(0, 1) ? k + 1 : k - 1;
    end else if (r < 58) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = phase_limit;
        default: k = phase_limit - 1;
      endcase
    end else begin
      k = (span == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, span));
    end
    return k;
  endfunction

  // One phase of random requests under one register setting.
  task automatic run_phase(input logic [CNT_W-1:0] cap, input logic [KEY_W-1:0] lim,
                           input int n, input int span, input int insert_pct,
                           input bit idle);
    logic op;
    logic [KEY_W-1:0] k;
    int gap;
    drain();
    set_registers(cap, lim);
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_FIND;
      k = pick_key(span);
      if (op == OP_INSERT) issued_keys.push_back(k);
      send_request(op, k);
      if (burst_left > 0) burst_left--;
      if (i == n / 2) begin
        // Let the block run dry once per phase.
        drain();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = (idle && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Run timeout.
  initial begin
    #5_000_000;
    $display("sorted_key_table_find_insert test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: capacity zero, default limit.
    send_request(OP_FIND, 32'h0);
    send_request(OP_INSERT, 32'h5);
    send_request(OP_INSERT, 32'h00FF_FFFF);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    drain();

    // Small table: inserts at both ends and in the middle, then a full table.
    set_registers(9'd4, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'd100);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFE);
    send_request(OP_INSERT, 32'd50);
    send_request(OP_INSERT, 32'd200);
    send_request(OP_INSERT, 32'd100);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'd51);
    drain();

    // Capacity above the table size, and a limit that rejects every insert.
    set_registers(9'd511, 32'h0);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_FIND, 32'h0);
    drain();

    // One-entry table with keys either side of the limit.
    set_registers(9'd1, 32'h10);
    send_request(OP_INSERT, 32'h0F);
    send_request(OP_INSERT, 32'h10);
    send_request(OP_INSERT, 32'h3);
    send_request(OP_INSERT, 32'h0F);

    // Random phases over a range of settings.
    run_phase(9'd256, 32'hFFFF_FFFF, 420, 0, 80, 1'b1);
    run_phase(9'd511, KEY_W'($urandom), 200, 127, 60, 1'b1);
    run_phase(9'd0, KEY_LIMIT_RESET, 80, 0, 50, 1'b0);
    run_phase(9'd1, 32'd1000, 100, 2000, 60, 1'b1);
    run_phase(9'd17, 32'h8000_0000, 200, 0, 70, 1'b1);
    for (int p = 0; p < 3; p++) begin
      run_phase(CNT_W'($urandom_range(0, 300)), KEY_W'($urandom), 130,
                ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 255 : 65535),
                $urandom_range(40, 90), p != 1);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_key_table_find_insert test passed");
    end else begin
      $display("sorted_key_table_find_insert test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/skt_pkg.sv
sv/skt_cell.sv
sv/skt_enc.sv
sv/sorted_key_table_find_insert.sv
verif/sorted_key_table_find_insert_check.sv
verif/sorted_key_table_find_insert_test.sv
